### design/rbpm_pkg.sv
package rbpm_pkg;
    localparam int NUM_SLOTS = 32;
    localparam int NUM_SUBS  = 16;
    localparam int SLOT_W    = 5;
    localparam int SUB_W     = 4;
    localparam int REF_W     = 8;
    localparam int SIZE_W    = 24;
    localparam int CFG_W     = 24;

    localparam logic [3:0] OP_ALLOC   = 4'd0;
    localparam logic [3:0] OP_SETSIZE = 4'd1;
    localparam logic [3:0] OP_PUBLISH = 4'd2;
    localparam logic [3:0] OP_ACQUIRE = 4'd3;
    localparam logic [3:0] OP_RELEASE = 4'd4;
    localparam logic [3:0] OP_PULL    = 4'd5;
    localparam logic [3:0] OP_SUB     = 4'd6;
    localparam logic [3:0] OP_UNSUB   = 4'd7;
    localparam logic [3:0] OP_INSPECT = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPARAM = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_STATE    = 3'd3;
    localparam logic [2:0] ST_NODATA   = 3'd4;
    localparam logic [2:0] ST_TYPE     = 3'd5;
    localparam logic [2:0] ST_UNDER    = 3'd6;

    localparam logic [1:0] CFG_SIZE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_SLOTS      = 2'd1;
    localparam logic [1:0] CFG_SUBS       = 2'd2;

    typedef struct packed {
        logic             exec;
        logic             note_step;
        logic             note_final;
        logic [SUB_W:0]   note_idx;
    } t_cmd;

    typedef struct packed {
        logic             multi;
        logic             note_hit;
        logic             note_done;
    } t_stat;
endpackage

### design/rbpm_ctrl.sv
module rbpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_out_note,
    output logic           o_out_last,
    output rbpm_pkg::t_cmd o_cmd,
    input  rbpm_pkg::t_stat i_stat
);
    import rbpm_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    logic [1:0]       r_state, n_state;
    logic [SUB_W:0]   r_idx, n_idx;
    logic             r_ov, n_ov, r_note, n_note, r_last, n_last;
    logic             w_free;

    assign w_free      = !r_ov || i_out_ready;
    assign o_ready     = (r_state == S_IDLE) && w_free;
    assign o_out_valid = r_ov;
    assign o_out_note  = r_note;
    assign o_out_last  = r_last;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_ov = r_ov && !i_out_ready;
        n_note = r_note;
        n_last = r_last;
        o_cmd.exec = 1'b0;
        o_cmd.note_step = 1'b0;
        o_cmd.note_final = 1'b0;
        o_cmd.note_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.exec = 1'b1;
                    if (i_stat.multi) begin
                        n_state = S_SCAN;
                        n_idx = '0;
                    end else begin
                        n_ov = 1'b1;
                        n_note = 1'b0;
                        n_last = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_free) begin
                    if (i_stat.note_done) begin
                        o_cmd.note_final = 1'b1;
                        n_ov = 1'b1;
                        n_note = 1'b0;
                        n_last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.note_step = 1'b1;
                        n_idx = r_idx + 1'b1;
                        if (i_stat.note_hit) begin
                            n_ov = 1'b1;
                            n_note = 1'b1;
                            n_last = 1'b0;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_ov <= 1'b0;
            r_note <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_ov <= n_ov;
            r_note <= n_note;
            r_last <= n_last;
        end
    end
endmodule

### design/rbpm_dp.sv
module rbpm_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [rbpm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [3:0]                i_operation,
    input  logic [4:0]                i_slot,
    input  logic [1:0]                i_data_type,
    input  logic [23:0]               i_size,
    input  logic [3:0]                i_subscriber,
    input  rbpm_pkg::t_cmd            i_cmd,
    output rbpm_pkg::t_stat           o_stat,
    output logic [2:0]                o_status,
    output logic [4:0]                o_slot_out,
    output logic [3:0]                o_subscriber_out,
    output logic [1:0]                o_type_out,
    output logic [23:0]               o_size_out,
    output logic [7:0]                o_refcount_out
);
    import rbpm_pkg::*;
    localparam logic [REF_W-1:0] REF_MAX = '1;

    logic [NUM_SLOTS-1:0] r_use, r_pub;
    logic [REF_W-1:0]     r_ref [NUM_SLOTS];
    logic [1:0]           r_ty  [NUM_SLOTS];
    logic [SIZE_W-1:0]    r_sz  [NUM_SLOTS];
    logic [NUM_SUBS-1:0]  r_sv;
    logic [1:0]           r_st  [NUM_SUBS];
    logic                 r_lv;
    logic [SLOT_W-1:0]    r_ls;
    logic [SIZE_W-1:0]    r_lim;
    logic [5:0]           r_ns;
    logic [4:0]           r_nb;
    logic [SLOT_W-1:0]    r_ps;
    logic [2:0]           r_status;
    logic [SLOT_W-1:0]    r_oslot;
    logic [SUB_W-1:0]     r_osub;
    logic [1:0]           r_oty;
    logic [SIZE_W-1:0]    r_osz;
    logic [REF_W-1:0]     r_oref;

    logic [5:0] w_ns;
    logic [4:0] w_nb;
    logic       w_ffound, w_sfound;
    logic [SLOT_W-1:0] w_free;
    logic [SUB_W-1:0]  w_sfree;
    logic       w_srange, w_is_pub;
    logic [SUB_W-1:0]  w_nix;

    assign w_ns = (r_ns > 6'(NUM_SLOTS)) ? 6'(NUM_SLOTS) : r_ns;
    assign w_nb = (r_nb > 5'(NUM_SUBS)) ? 5'(NUM_SUBS) : r_nb;
    assign w_srange = {1'b0, i_slot} < w_ns;
    assign w_is_pub = (i_operation == OP_PUBLISH) && w_srange && r_use[i_slot]
                      && !r_pub[i_slot];
    assign o_stat.multi = w_is_pub;

    always_comb begin
        w_ffound = 1'b0;
        w_free = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (6'(i) < w_ns && !r_use[i] && r_ref[i] == '0) begin
                w_ffound = 1'b1;
                w_free = SLOT_W'(i);
            end
        end
        w_sfound = 1'b0;
        w_sfree = '0;
        for (int j = NUM_SUBS - 1; j >= 0; j--) begin
            if (5'(j) < w_nb && !r_sv[j]) begin
                w_sfound = 1'b1;
                w_sfree = SUB_W'(j);
            end
        end
    end

    assign w_nix = i_cmd.note_idx[SUB_W-1:0];
    assign o_stat.note_hit = r_sv[w_nix] &&
        (r_st[w_nix] == 2'd0 || r_st[w_nix] == r_ty[r_ps]);
    assign o_stat.note_done = i_cmd.note_idx >= w_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
            r_pub <= '0;
            r_sv <= '0;
            r_lv <= 1'b0;
            r_ls <= '0;
            r_lim <= 24'd4194304;
            r_ns <= 6'd32;
            r_nb <= 5'd16;
            r_ps <= '0;
            r_status <= ST_OK;
            r_oslot <= '0;
            r_osub <= '0;
            r_oty <= '0;
            r_osz <= '0;
            r_oref <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_ref[i] <= '0;
                r_ty[i] <= '0;
                r_sz[i] <= '0;
            end
            for (int j = 0; j < NUM_SUBS; j++) r_st[j] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SIZE_LIMIT: r_lim <= i_cfg_data[SIZE_W-1:0];
                    CFG_SLOTS:      r_ns <= i_cfg_data[5:0];
                    CFG_SUBS:       r_nb <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.note_step) begin
                r_status <= ST_OK;
                r_oslot <= r_ps;
                r_osub <= w_nix;
                r_oty <= r_ty[r_ps];
                r_osz <= r_sz[r_ps];
                r_oref <= r_ref[r_ps];
            end else if (i_cmd.note_final) begin
                r_status <= ST_OK;
                r_oslot <= r_ps;
                r_osub <= '0;
                r_oty <= r_ty[r_ps];
                r_osz <= r_sz[r_ps];
                r_oref <= r_ref[r_ps];
            end
            if (i_cmd.exec) begin
                r_status <= ST_BADPARAM;
                r_oslot <= '0;
                r_osub <= '0;
                r_oty <= '0;
                r_osz <= '0;
                r_oref <= '0;
                case (i_operation)
                    OP_ALLOC: begin
                        if (i_data_type == 2'd0 || i_size > r_lim) r_status <= ST_BADPARAM;
                        else if (!w_ffound) r_status <= ST_FULL;
                        else begin
                            r_use[w_free] <= 1'b1;
                            r_pub[w_free] <= 1'b0;
                            r_ty[w_free] <= i_data_type;
                            r_sz[w_free] <= i_size;
                            r_ref[w_free] <= REF_W'(1);
                            r_status <= ST_OK;
                            r_oslot <= w_free;
                            r_oty <= i_data_type;
                            r_osz <= i_size;
                            r_oref <= REF_W'(1);
                        end
                    end
                    OP_PULL: begin
                        if (!r_lv) r_status <= ST_NODATA;
                        else if (i_data_type != 2'd0 && r_ty[r_ls] != i_data_type)
                            r_status <= ST_TYPE;
                        else begin
                            r_status <= ST_OK;
                            r_oslot <= r_ls;
                            r_oty <= r_ty[r_ls];
                            r_osz <= r_sz[r_ls];
                            if (r_ref[r_ls] != REF_MAX) begin
                                r_ref[r_ls] <= r_ref[r_ls] + 1'b1;
                                r_oref <= r_ref[r_ls] + 1'b1;
                            end else r_oref <= r_ref[r_ls];
                        end
                    end
                    OP_SUB: begin
                        if (!w_sfound) r_status <= ST_FULL;
                        else begin
                            r_sv[w_sfree] <= 1'b1;
                            r_st[w_sfree] <= i_data_type;
                            r_status <= ST_OK;
                            r_osub <= w_sfree;
                        end
                    end
                    OP_UNSUB: begin
                        if ({1'b0, i_subscriber} < w_nb) begin
                            r_sv[i_subscriber] <= 1'b0;
                            r_status <= ST_OK;
                            r_osub <= i_subscriber;
                        end
                    end
                    OP_SETSIZE: begin
                        if (!w_srange) r_status <= ST_BADPARAM;
                        else if (!r_use[i_slot]) r_status <= ST_STATE;
                        else if (!r_pub[i_slot] && i_size <= r_sz[i_slot]) begin
                            r_sz[i_slot] <= i_size;
                            r_status <= ST_OK;
                            r_oslot <= i_slot;
                            r_oty <= r_ty[i_slot];
                            r_osz <= i_size;
                            r_oref <= r_ref[i_slot];
                        end
                    end
                    OP_PUBLISH: begin
                        if (!w_srange) r_status <= ST_BADPARAM;
                        else if (!w_is_pub) r_status <= ST_STATE;
                        else begin
                            r_pub[i_slot] <= 1'b1;
                            r_ps <= i_slot;
                            r_lv <= 1'b1;
                            r_ls <= i_slot;
                            if (r_lv && r_ls != i_slot && r_ref[r_ls] == REF_W'(1)) begin
                                r_use[r_ls] <= 1'b0;
                                r_pub[r_ls] <= 1'b0;
                                r_ty[r_ls] <= '0;
                                r_sz[r_ls] <= '0;
                                r_ref[r_ls] <= '0;
                            end else if (r_lv && r_ls != i_slot && r_ref[r_ls] != '0)
                                r_ref[r_ls] <= r_ref[r_ls] - 1'b1;
                            if (r_lv && r_ls == i_slot) begin
                                if (r_ref[i_slot] == '0) r_ref[i_slot] <= REF_W'(1);
                            end else if (r_ref[i_slot] != REF_MAX)
                                r_ref[i_slot] <= r_ref[i_slot] + 1'b1;
                        end
                    end
                    OP_ACQUIRE: begin
                        if (!w_srange) r_status <= ST_BADPARAM;
                        else if (!r_use[i_slot]) r_status <= ST_STATE;
                        else begin
                            r_status <= ST_OK;
                            r_oslot <= i_slot;
                            r_oty <= r_ty[i_slot];
                            r_osz <= r_sz[i_slot];
                            if (r_ref[i_slot] != REF_MAX) begin
                                r_ref[i_slot] <= r_ref[i_slot] + 1'b1;
                                r_oref <= r_ref[i_slot] + 1'b1;
                            end else r_oref <= r_ref[i_slot];
                        end
                    end
                    OP_RELEASE: begin
                        if (!w_srange) r_status <= ST_BADPARAM;
                        else if (r_ref[i_slot] == '0) r_status <= ST_UNDER;
                        else begin
                            r_status <= ST_OK;
                            r_oslot <= i_slot;
                            if (r_ref[i_slot] == REF_W'(1)) begin
                                r_use[i_slot] <= 1'b0;
                                r_pub[i_slot] <= 1'b0;
                                r_ty[i_slot] <= '0;
                                r_sz[i_slot] <= '0;
                                r_ref[i_slot] <= '0;
                                if (r_lv && r_ls == i_slot) r_lv <= 1'b0;
                            end else begin
                                r_ref[i_slot] <= r_ref[i_slot] - 1'b1;
                                r_oty <= r_ty[i_slot];
                                r_osz <= r_sz[i_slot];
                                r_oref <= r_ref[i_slot] - 1'b1;
                            end
                        end
                    end
                    OP_INSPECT: begin
                        if (w_srange) begin
                            r_status <= ST_OK;
                            r_oslot <= i_slot;
                            r_oty <= r_ty[i_slot];
                            r_osz <= r_sz[i_slot];
                            r_oref <= r_ref[i_slot];
                        end
                    end
                    default: r_status <= ST_BADPARAM;
                endcase
            end
        end
    end

    assign o_status = r_status;
    assign o_slot_out = r_oslot;
    assign o_subscriber_out = r_osub;
    assign o_type_out = r_oty;
    assign o_size_out = r_osz;
    assign o_refcount_out = r_oref;
endmodule

### design/refcounted_buffer_pool_manager_unit.sv
// Reference-counted buffer pool manager.
// Input channel (i_valid/o_ready) carries one request: operation, slot, type,
// size and subscriber index. Output channel (o_valid/i_ready) returns results.
// Every request gives one result with o_last set, except a valid publish, which
// gives one notification per matching subscriber and then the final result.
// Latency: a single-result request shows its result the cycle after acceptance,
// and with the receiver ready a new request is taken every cycle.
// Publish walks the configured subscriber table one entry per cycle in the
// controller while the receiver is ready; the final result follows the walk
// and no new request is taken until the controller is back in idle.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect on the
// next edge; the user makes them only while idle (not enforced by the block).
// Reset clears the pool, the subscriber table and the latest mark and loads
// the register defaults. A stalled receiver holds the result register and the
// subscriber walk; no new request is accepted until the register is free.
module refcounted_buffer_pool_manager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_operation,
    input  logic [4:0]  i_slot,
    input  logic [1:0]  i_data_type,
    input  logic [23:0] i_size,
    input  logic [3:0]  i_subscriber,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_is_notification,
    output logic [4:0]  o_slot_out,
    output logic [3:0]  o_subscriber_out,
    output logic [1:0]  o_type_out,
    output logic [23:0] o_size_out,
    output logic [7:0]  o_refcount_out,
    output logic        o_last
);
    import rbpm_pkg::*;
    t_cmd  w_cmd;
    t_stat w_stat;

    rbpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .o_out_note(o_is_notification),
        .o_out_last(o_last), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    rbpm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_operation(i_operation), .i_slot(i_slot),
        .i_data_type(i_data_type), .i_size(i_size), .i_subscriber(i_subscriber),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_status(o_status), .o_slot_out(o_slot_out),
        .o_subscriber_out(o_subscriber_out), .o_type_out(o_type_out),
        .o_size_out(o_size_out), .o_refcount_out(o_refcount_out)
    );
endmodule
